// ===== rtl/core/bmp_pkg.sv =====
package bmp_pkg;

    // Frame geometry; both sizes are multiples of four
    localparam int FRAME_ROWS = 256;
    localparam int FRAME_COLS = 256;
    localparam int ROW_W      = $clog2(FRAME_ROWS);
    localparam int COL_W      = $clog2(FRAME_COLS);

    // One running maximum per block column, block column index taken modulo the depth
    localparam int MAX_DEPTH  = 128;
    localparam int SLOT_W     = $clog2(MAX_DEPTH);

    localparam int PIX_W      = 16;
    localparam int COORD_W    = 8;

    // Job queue between front and back; depth is a power of two
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    // Block size minus one for each mode
    localparam logic [1:0] MSK_DENSE  = 2'd1;
    localparam logic [1:0] MSK_SPARSE = 2'd3;

    localparam logic MODE_DENSE  = 1'b0;
    localparam logic MODE_SPARSE = 1'b1;

    // One finished block: top left corner, maximum and the mode it was pooled in
    typedef struct packed {
        logic [ROW_W-1:0]        r0;
        logic [COL_W-1:0]        c0;
        logic signed [PIX_W-1:0] value;
        logic                    mode;
    } job_t;

    function automatic logic [1:0] block_mask(input logic mode);
        block_mask = (mode == MODE_SPARSE) ? MSK_SPARSE : MSK_DENSE;
    endfunction

endpackage

// ===== rtl/core/block_max_pool_replicate_unit.sv =====
// Streaming block max pooling with replication. Pixels arrive one transaction per
// cycle in raster order on the s_ channel; s_frame_start marks row 0, column 0. In
// dense mode (pool_mode 0) each 2x2 block is reduced to its maximum, in sparse mode
// (pool_mode 1) each 4x4 block is reduced to the maximum of its four even-offset
// pixels. On a block's bottom right pixel the maximum leaves on the m_ channel once
// per block position, raster order within the block, one transaction per cycle
// while m_ready is high, with m_block_last on the final one: 4 results per dense
// block, 16 per sparse block. The input takes one pixel per cycle while the
// 4-entry block queue has room. A block's first result follows its last pixel
// through the second stage, the block queue and the back's job register.
// Sustained, the output port sets the pace: one result per cycle, which over a
// frame is one result per pixel. The 128-entry running maximum store is read
// and rewritten over two stages with forwarding, so neighbouring pixels of one
// block need no wait. It has no clearing pass; every block writes its entry on its
// first pixel. Write pool_mode only while the block is idle.
module block_max_pool_replicate_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [bmp_pkg::PIX_W-1:0] s_pixel_value,
    input  logic                             s_frame_start,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bmp_pkg::COORD_W-1:0]      m_out_row,
    output logic [bmp_pkg::COORD_W-1:0]      m_out_col,
    output logic signed [bmp_pkg::PIX_W-1:0] m_pooled_value,
    output logic                             m_block_last
);

    logic          pool_mode_reg;
    logic          push_valid, push_ready, pop_valid, pop_ready;
    bmp_pkg::job_t push_data, pop_data;

    // Hold the pooling mode; dense after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_mode_reg <= bmp_pkg::MODE_DENSE;
        end else if (cfg_we) begin
            pool_mode_reg <= cfg_wdata;
        end
    end

    // Front: track position, update running maxima, flag finished blocks
    bmp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pool_mode     (pool_mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .s_frame_start (s_frame_start),
        .q_push_valid  (push_valid),
        .q_push_ready  (push_ready),
        .q_push_data   (push_data)
    );

    // Queue finished blocks so either side can stall on its own
    bmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: replicate each block maximum over every position of its block
    bmp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col),
        .m_pooled_value (m_pooled_value),
        .m_block_last   (m_block_last)
    );

endmodule

// ===== rtl/core/bmp_front.sv =====
module bmp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pool_mode,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [bmp_pkg::PIX_W-1:0] s_pixel_value,
    input  logic                          s_frame_start,
    output logic                          q_push_valid,
    input  logic                          q_push_ready,
    output bmp_pkg::job_t                 q_push_data
);

    localparam int ROW_W  = bmp_pkg::ROW_W;
    localparam int COL_W  = bmp_pkg::COL_W;
    localparam int SLOT_W = bmp_pkg::SLOT_W;
    localparam int PIX_W  = bmp_pkg::PIX_W;

    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;

    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W:0]   r_inc;
    logic [COL_W:0]   c_inc;
    logic [1:0]       msk, rr, cc;
    logic [SLOT_W-1:0] slot_d;
    logic             upd_d, first_d, end_d, accept;

    // Second stage: read-modify-write of the running maximum
    logic                    st1_valid_reg;
    logic signed [PIX_W-1:0] st1_px_reg;
    logic [SLOT_W-1:0]       st1_slot_reg;
    logic                    st1_upd_reg, st1_first_reg, st1_end_reg, st1_mode_reg;
    logic [ROW_W-1:0]        st1_r0_reg;
    logic [COL_W-1:0]        st1_c0_reg;
    logic signed [PIX_W-1:0] rd_data_reg, byp_val_reg;
    logic                    byp_hit_reg;
    logic signed [PIX_W-1:0] old_val, new_val, emit_val;
    logic                    st1_adv, mem_we, byp_hit_d;

    logic signed [PIX_W-1:0] running_max_mem [bmp_pkg::MAX_DEPTH];

    assign accept = s_valid && s_ready;

    always_comb begin
        r_cur = s_frame_start ? '0 : row_count_reg;
        c_cur = s_frame_start ? '0 : col_count_reg;
        msk   = bmp_pkg::block_mask(pool_mode);
        rr    = (pool_mode == bmp_pkg::MODE_SPARSE) ? r_cur[1:0] : {1'b0, r_cur[0]};
        cc    = (pool_mode == bmp_pkg::MODE_SPARSE) ? c_cur[1:0] : {1'b0, c_cur[0]};
        slot_d = (pool_mode == bmp_pkg::MODE_SPARSE) ? SLOT_W'(c_cur >> 2)
                                                     : SLOT_W'(c_cur >> 1);
        upd_d   = (pool_mode == bmp_pkg::MODE_DENSE) || (!rr[0] && !cc[0]);
        first_d = (rr == 2'd0) && (cc == 2'd0);
        end_d   = (rr == msk) && (cc == msk);

        // Advance position counters, wrap at the frame edges
        c_inc = {1'b0, c_cur} + (COL_W+1)'(1);
        r_inc = {1'b0, r_cur} + (ROW_W+1)'(1);
        row_count_next = r_cur;
        if (c_inc >= (COL_W+1)'(bmp_pkg::FRAME_COLS)) begin
            col_count_next = '0;
            if (r_inc >= (ROW_W+1)'(bmp_pkg::FRAME_ROWS)) begin
                row_count_next = '0;
            end else begin
                row_count_next = r_inc[ROW_W-1:0];
            end
        end else begin
            col_count_next = c_inc[COL_W-1:0];
        end
    end

    always_comb begin
        old_val  = byp_hit_reg ? byp_val_reg : rd_data_reg;
        new_val  = (st1_first_reg || (st1_px_reg > old_val)) ? st1_px_reg : old_val;
        emit_val = st1_upd_reg ? new_val : old_val;
    end

    assign st1_adv   = !st1_end_reg || q_push_ready;
    assign s_ready   = !st1_valid_reg || st1_adv;
    assign mem_we    = st1_valid_reg && st1_upd_reg && st1_adv;
    assign byp_hit_d = mem_we && (st1_slot_reg == slot_d);

    assign q_push_valid      = st1_valid_reg && st1_end_reg;
    assign q_push_data.r0    = st1_r0_reg;
    assign q_push_data.c0    = st1_c0_reg;
    assign q_push_data.value = emit_val;
    assign q_push_data.mode  = st1_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
                st1_valid_reg <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_px_reg    <= s_pixel_value;
            st1_slot_reg  <= slot_d;
            st1_upd_reg   <= upd_d;
            st1_first_reg <= first_d;
            st1_end_reg   <= end_d;
            st1_mode_reg  <= pool_mode;
            st1_r0_reg    <= r_cur - ROW_W'(msk);
            st1_c0_reg    <= c_cur - COL_W'(msk);
            byp_hit_reg   <= byp_hit_d;
            byp_val_reg   <= new_val;
        end
    end

    // Running maximum store: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            running_max_mem[st1_slot_reg] <= new_val;
        end
        if (accept) begin
            rd_data_reg <= running_max_mem[slot_d];
        end
    end

endmodule

// ===== rtl/core/bmp_queue.sv =====
module bmp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  bmp_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output bmp_pkg::job_t pop_data
);

    localparam int PTR_W = bmp_pkg::Q_PTR_W;

    bmp_pkg::job_t    entry_reg [bmp_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(bmp_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/bmp_back.sv =====
module bmp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  bmp_pkg::job_t                  pop_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bmp_pkg::COORD_W-1:0]    m_out_row,
    output logic [bmp_pkg::COORD_W-1:0]    m_out_col,
    output logic signed [bmp_pkg::PIX_W-1:0] m_pooled_value,
    output logic                           m_block_last
);

    localparam int ROW_W   = bmp_pkg::ROW_W;
    localparam int COL_W   = bmp_pkg::COL_W;
    localparam int COORD_W = bmp_pkg::COORD_W;

    bmp_pkg::job_t job_reg;
    logic          job_valid_reg;
    logic [1:0]    i_reg, j_reg;
    logic [1:0]    msk;
    logic          last, m_accept, load;

    assign msk       = bmp_pkg::block_mask(job_reg.mode);
    assign last      = (i_reg == msk) && (j_reg == msk);
    assign m_accept  = m_valid && m_ready;
    assign pop_ready = !job_valid_reg || (m_accept && last);
    assign load      = pop_valid && pop_ready;

    assign m_valid        = job_valid_reg;
    assign m_out_row      = COORD_W'(job_reg.r0 + ROW_W'(i_reg));
    assign m_out_col      = COORD_W'(job_reg.c0 + COL_W'(j_reg));
    assign m_pooled_value = job_reg.value;
    assign m_block_last   = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end else begin
            if (load) begin
                job_valid_reg <= 1'b1;
                i_reg         <= '0;
                j_reg         <= '0;
            end else if (m_accept && last) begin
                job_valid_reg <= 1'b0;
            end else if (m_accept) begin
                if (j_reg == msk) begin
                    j_reg <= '0;
                    i_reg <= i_reg + 2'd1;
                end else begin
                    j_reg <= j_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= pop_data;
        end
    end

endmodule

// ===== rtl/core/bmp_checker.sv =====
module bmp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bmp_pkg::COORD_W-1:0]      m_out_row,
    input logic [bmp_pkg::COORD_W-1:0]      m_out_col,
    input logic signed [bmp_pkg::PIX_W-1:0] m_pooled_value,
    input logic                             m_block_last
);

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_pooled_value) && $stable(m_block_last))
        else $error("stalled result changed");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A block run continues without a gap until its last result
    a_run_unbroken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_block_last |=> m_valid)
        else $error("gap inside a block run");

    // The last result of a block sits at an odd row and odd column
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_last |-> m_out_row[0] && m_out_col[0])
        else $error("block last not at bottom right corner");

    // The value stays the same across one block run
    a_run_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_block_last |=> $stable(m_pooled_value))
        else $error("value changed inside a block run");

endmodule

bind block_max_pool_replicate_unit bmp_checker u_checker (.*);
